@@ rtl/nsl_pkg.sv @@
package nsl_pkg;

  localparam int NSL_MAX_SEEDS  = 64;
  localparam int NSL_COORD_BITS = 12;
  localparam int NSL_QDEPTH     = 2;

  localparam int MODE_W  = 2;
  localparam int COORD_W = 12;
  localparam int LABEL_W = 7;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } cmd_t;

endpackage

@@ rtl/nsl_front.sv @@
module nsl_front import nsl_pkg::*; #(
  parameter int COORD_BITS = NSL_COORD_BITS
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [COORD_W-1:0] in_row,
  input  logic [COORD_W-1:0] in_col,
  input  logic               q_full,
  output logic               push,
  output cmd_t               push_cmd
);

  localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] CMASK = COORD_W'((1 << CW) - 1);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd.row = in_row & CMASK;
    push_cmd.col = in_col & CMASK;
    unique case (in_mode)
      MODE_CLEAR:  push_cmd.op = OP_CLEAR;
      MODE_APPEND: push_cmd.op = OP_APPEND;
      MODE_QUERY:  push_cmd.op = OP_QUERY;
      default:     push_cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ rtl/nsl_queue.sv @@
module nsl_queue import nsl_pkg::*; #(
  parameter int DEPTH = NSL_QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/nsl_back.sv @@
module nsl_back import nsl_pkg::*; #(
  parameter int MAX_SEEDS  = NSL_MAX_SEEDS,
  parameter int COORD_BITS = NSL_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [LABEL_W-1:0] out_label,
  output logic               out_status
);

  localparam int CW     = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int IDX_W  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEEDS + 1);
  localparam int DIST_W = 2 * CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    seed_total_r;
  logic [CNT_W-1:0]    rd_cnt_r;
  logic                a_vld_r;
  logic [CNT_W-1:0]    a_lab_r;
  logic                b_vld_r;
  logic [CNT_W-1:0]    b_lab_r;
  logic [2*CW-1:0]     sq_row_r;
  logic [2*CW-1:0]     sq_col_r;
  logic [CNT_W-1:0]    best_r;
  logic [CNT_W-1:0]    exact_r;
  logic [DIST_W-1:0]   best_dist_r;
  logic [CW-1:0]       q_row_r;
  logic [CW-1:0]       q_col_r;
  logic                out_valid_r;
  logic [LABEL_W-1:0]  out_label_r;
  logic                out_status_r;

  logic [2*CW-1:0]     seed_mem [MAX_SEEDS];
  logic [2*CW-1:0]     rd_data_r;

  logic                out_free;
  logic                table_full;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic [CW-1:0]       seed_row;
  logic [CW-1:0]       seed_col;
  logic [CW-1:0]       dr;
  logic [CW-1:0]       dc;
  logic [DIST_W-1:0]   sq_dist;
  logic [CNT_W-1:0]    pick;

  assign out_free   = !out_valid_r || out_ready;
  assign q_pop      = (state_r == ST_IDLE) && q_valid && out_free;
  assign table_full = (seed_total_r >= CNT_W'(MAX_SEEDS));
  assign wr_en      = q_pop && (q_cmd.op == OP_APPEND) && !table_full;
  assign wr_addr    = seed_total_r[IDX_W-1:0];
  assign rd_addr    = rd_cnt_r[IDX_W-1:0];

  assign seed_row = rd_data_r[2*CW-1:CW];
  assign seed_col = rd_data_r[CW-1:0];
  assign dr       = (q_row_r > seed_row) ? (q_row_r - seed_row) : (seed_row - q_row_r);
  assign dc       = (q_col_r > seed_col) ? (q_col_r - seed_col) : (seed_col - q_col_r);
  assign sq_dist  = DIST_W'(sq_row_r) + DIST_W'(sq_col_r);
  assign pick     = (exact_r != '0) ? exact_r : best_r;

  assign out_valid  = out_valid_r;
  assign out_label  = out_label_r;
  assign out_status = out_status_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seed_mem[wr_addr] <= {q_cmd.row[CW-1:0], q_cmd.col[CW-1:0]};
    end
    rd_data_r <= seed_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seed_total_r <= '0;
      rd_cnt_r     <= '0;
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      a_vld_r  <= 1'b0;
      b_vld_r  <= a_vld_r;
      b_lab_r  <= a_lab_r;
      sq_row_r <= (2*CW)'(dr) * (2*CW)'(dr);
      sq_col_r <= (2*CW)'(dc) * (2*CW)'(dc);
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_cmd.op)
              OP_CLEAR: begin
                seed_total_r <= '0;
                out_valid_r  <= 1'b1;
                out_label_r  <= '0;
                out_status_r <= 1'b0;
              end
              OP_APPEND: begin
                if (!table_full) begin
                  seed_total_r <= seed_total_r + 1'b1;
                end
                out_valid_r  <= 1'b1;
                out_label_r  <= '0;
                out_status_r <= table_full;
              end
              OP_QUERY: begin
                q_row_r  <= q_cmd.row[CW-1:0];
                q_col_r  <= q_cmd.col[CW-1:0];
                rd_cnt_r <= '0;
                best_r   <= '0;
                exact_r  <= '0;
                state_r  <= ST_RUN;
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_label_r  <= '0;
                out_status_r <= 1'b0;
              end
            endcase
          end
        end
        ST_RUN: begin
          if (rd_cnt_r < seed_total_r) begin
            a_vld_r  <= 1'b1;
            a_lab_r  <= rd_cnt_r + 1'b1;
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end else if (!a_vld_r && !b_vld_r) begin
            state_r <= ST_FIN;
          end
          if (b_vld_r) begin
            if (sq_dist == '0) begin
              exact_r <= b_lab_r;
            end
            if ((best_r == '0) || (sq_dist < best_dist_r)) begin
              best_dist_r <= sq_dist;
              best_r      <= b_lab_r;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_label_r  <= LABEL_W'(pick);
            out_status_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seed_total_r <= CNT_W'(MAX_SEEDS))
    else $error("seed count exceeds table capacity");

  a_status_no_label: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_label_r == '0))
    else $error("dropped append carries a label");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!a_vld_r && !b_vld_r))
    else $error("distance pipeline busy while idle");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_cmd.op == OP_QUERY)) |=> (state_r == ST_RUN))
    else $error("query transfer did not start a scan");
`endif

endmodule

@@ rtl/nearest_seed_labeler.sv @@
// Nearest seed labeler. Each input transfer carries a mode with a row and a
// column: mode 0 clears the seed table, mode 1 appends a seed and mode 2
// queries a pixel. Every input transfer yields exactly one output transfer,
// in order, with a label and a status. A query returns the 1-based index of
// the nearest stored seed, or 0 for an empty table. A seed lying exactly on
// the pixel wins, the last such seed if several do; otherwise ties go to the
// lowest index. An append to a full table is dropped with status 1.
// Input transfers enter a two-entry queue and are executed in order by a
// back end that holds the seeds in a memory. A clear or append produces its
// result in the cycle after it is taken from the queue, so these sustain one
// item per cycle while the receiver is ready. A query scans the stored seeds
// one per cycle through a read, square and compare pipeline, then registers
// its result and returns to idle; only then does the next item leave the
// queue, so that scan sets the rate.
// Reset empties the seed table and the queue and drops any pending result.
// When the receiver stalls, the result waits in the output register, the
// back end takes no further items, and in_ready falls once the queue is full.
module nearest_seed_labeler import nsl_pkg::*; #(
  parameter int MAX_SEEDS  = NSL_MAX_SEEDS,
  parameter int COORD_BITS = NSL_COORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [COORD_W-1:0] in_row,
  input  logic [COORD_W-1:0] in_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LABEL_W-1:0] out_label,
  output logic               out_status
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  nsl_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_row   (in_row),
    .in_col   (in_col),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nsl_queue #(
    .DEPTH(NSL_QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (q_pop)
  );

  nsl_back #(
    .MAX_SEEDS  (MAX_SEEDS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_label  (out_label),
    .out_status (out_status)
  );

endmodule
